[rtl/xcfh_pkg.sv]
package xcfh_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int WINDOW      = 257;
    localparam int MIN_FRAME   = 4;
    localparam int SKIP_MAX    = 1023;
    localparam int SKIP_W      = 10;
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam int N_W         = $clog2(WINDOW + 1);

    // candidate search: slot j holds the frame of length j + MIN_FRAME
    localparam int GRP         = 16;
    localparam int SLOTS       = GRP * GRP;
    localparam int NCAND       = WINDOW - MIN_FRAME + 1;

    typedef struct packed {
        logic [7:0] dat;
        logic [7:0] pfx;
        logic       vld;
    } t_cell;

    typedef struct packed {
        logic           hit;
        logic [7:0]     src;
        logic [7:0]     dst;
        logic [7:0]     cmd;
        logic [N_W-1:0] n;
    } t_cand;

endpackage

[rtl/xcfh_cell.sv]
module xcfh_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  logic           i_clr,
    input  xcfh_pkg::t_cell i_prev,
    input  logic [7:0]     i_run,
    input  logic [7:0]     i_len_ref,
    input  logic           i_cand,
    output xcfh_pkg::t_cell o_cell,
    output logic           o_hit
);

    logic [7:0] r_dat;
    logic [7:0] r_pfx;
    logic       r_vld;
    logic       r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_clr) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_prev.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_dat <= i_prev.dat;
            r_pfx <= i_prev.pfx;
        end
        // this cell is the frame start; the neighbour holds the length byte
        r_hit <= i_cand && r_vld && (r_pfx == i_run) && (i_prev.dat == i_len_ref);
    end

    assign o_cell.dat = r_dat;
    assign o_cell.pfx = r_pfx;
    assign o_cell.vld = r_vld;
    assign o_hit      = r_hit;

endmodule

[rtl/xcfh_group.sv]
module xcfh_group (
    input  logic            i_clk,
    input  xcfh_pkg::t_cand i_cand [xcfh_pkg::GRP],
    output xcfh_pkg::t_cand o_best
);

    xcfh_pkg::t_cand n_best;
    xcfh_pkg::t_cand r_best;

    // highest slot (longest frame) wins
    always_comb begin
        n_best = '0;
        for (int i = 0; i < xcfh_pkg::GRP; i++) begin
            if (i_cand[i].hit) begin
                n_best = i_cand[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
    end

    assign o_best = r_best;

endmodule

[rtl/xor_checked_frame_hunter_core.sv]
// Channel  Dir  Handshake            Payload
// in       in   i_valid / o_ready    i_rx_byte
// out      out  o_valid / i_ready    o_frame_found, o_source_addr, o_dest_addr,
//                                    o_length_byte, o_command_byte,
//                                    o_skipped_bytes, o_overflow
// One beat in gives one beat out. Each byte steps through accept, cell compare,
// group select, final select and result load before the next byte is taken.
// The byte cells shift once per accepted beat; the registered two-level
// priority tree over the 254 start cells sets the latency.
// Reset is synchronous and needs no clearing pass; the cell valid bits, state, fill, run and output valid clear.
// A pending result holds the block in its last step until the beat is taken.
module xor_checked_frame_hunter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_frame_found,
    output logic [7:0]  o_source_addr,
    output logic [7:0]  o_dest_addr,
    output logic [7:0]  o_length_byte,
    output logic [7:0]  o_command_byte,
    output logic [xcfh_pkg::SKIP_W-1:0] o_skipped_bytes,
    output logic        o_overflow
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIT,
        S_GRP,
        S_SEL,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [xcfh_pkg::FILL_W-1:0]   r_fill;
    logic [7:0]                    r_run;
    logic                          r_valid;
    logic                          r_found;
    logic [7:0]                    r_src;
    logic [7:0]                    r_dst;
    logic [7:0]                    r_len;
    logic [7:0]                    r_cmd;
    logic [xcfh_pkg::SKIP_W-1:0]   r_skip;
    logic                          r_ovf;

    logic                          in_acc;
    logic                          done_fire;
    logic                          ovf_now;
    logic                          clr;
    logic [xcfh_pkg::FILL_W-1:0]   skip_full;
    logic [xcfh_pkg::SKIP_W-1:0]   skip_sat;

    xcfh_pkg::t_cell               cell_in  [xcfh_pkg::WINDOW];
    xcfh_pkg::t_cell               cell_out [xcfh_pkg::WINDOW];
    logic [xcfh_pkg::WINDOW-1:0]   hit;
    xcfh_pkg::t_cand               slot     [xcfh_pkg::SLOTS];
    xcfh_pkg::t_cand               grp_best [xcfh_pkg::GRP];
    xcfh_pkg::t_cand               best;

    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign done_fire = (r_state == S_DONE) && (!r_valid || i_ready);
    assign ovf_now   = !best.hit && (r_fill >= xcfh_pkg::FILL_W'(xcfh_pkg::STORE_DEPTH));
    assign clr       = done_fire && (best.hit || ovf_now);

    // ---- cell chain: age 0 is the newest byte ----
    assign cell_in[0].dat = i_rx_byte;
    assign cell_in[0].pfx = r_run;
    assign cell_in[0].vld = 1'b1;

    for (genvar k = 0; k < xcfh_pkg::WINDOW; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign cell_in[k] = cell_out[k-1];
        end
        xcfh_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (in_acc),
            .i_clr     (clr),
            .i_prev    (cell_in[k]),
            .i_run     (r_run),
            .i_len_ref (8'(k - 1)),
            .i_cand    (k >= xcfh_pkg::MIN_FRAME - 1),
            .o_cell    (cell_out[k]),
            .o_hit     (hit[k])
        );
    end

    // ---- candidate slots: start cell k = j + 3 ----
    for (genvar j = 0; j < xcfh_pkg::SLOTS; j++) begin : g_slot
        if (j < xcfh_pkg::NCAND) begin : g_real
            localparam int K = j + xcfh_pkg::MIN_FRAME - 1;
            assign slot[j].hit = hit[K];
            assign slot[j].src = cell_out[K].dat;
            assign slot[j].dst = cell_out[K-2].dat;
            assign slot[j].cmd = cell_out[K-3].dat;
            assign slot[j].n   = xcfh_pkg::N_W'(j + xcfh_pkg::MIN_FRAME);
        end else begin : g_pad
            assign slot[j] = '0;
        end
    end

    for (genvar g = 0; g < xcfh_pkg::GRP; g++) begin : g_grp
        xcfh_group u_grp (
            .i_clk  (i_clk),
            .i_cand (slot[g*xcfh_pkg::GRP +: xcfh_pkg::GRP]),
            .o_best (grp_best[g])
        );
    end

    xcfh_group u_final (
        .i_clk  (i_clk),
        .i_cand (grp_best),
        .o_best (best)
    );

    assign skip_full = r_fill - xcfh_pkg::FILL_W'(best.n);
    assign skip_sat  = (skip_full > xcfh_pkg::FILL_W'(xcfh_pkg::SKIP_MAX))
                     ? xcfh_pkg::SKIP_W'(xcfh_pkg::SKIP_MAX)
                     : xcfh_pkg::SKIP_W'(skip_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_run   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (done_fire) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_fill  <= r_fill + xcfh_pkg::FILL_W'(1);
                        r_run   <= r_run ^ i_rx_byte;
                        r_state <= S_HIT;
                    end
                end
                S_HIT:  r_state <= S_GRP;
                S_GRP:  r_state <= S_SEL;
                S_SEL:  r_state <= S_DONE;
                S_DONE: begin
                    if (done_fire) begin
                        r_found <= best.hit;
                        r_src   <= best.hit ? best.src : 8'd0;
                        r_dst   <= best.hit ? best.dst : 8'd0;
                        r_len   <= best.hit ? 8'(best.n - xcfh_pkg::N_W'(2)) : 8'd0;
                        r_cmd   <= best.hit ? best.cmd : 8'd0;
                        r_skip  <= best.hit ? skip_sat : '0;
                        r_ovf   <= ovf_now;
                        if (clr) begin
                            r_fill <= '0;
                            r_run  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_frame_found   = r_found;
    assign o_source_addr   = r_src;
    assign o_dest_addr     = r_dst;
    assign o_length_byte   = r_len;
    assign o_command_byte  = r_cmd;
    assign o_skipped_bytes = r_skip;
    assign o_overflow      = r_ovf;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= xcfh_pkg::FILL_W'(xcfh_pkg::STORE_DEPTH))
        else $error("fill count past store depth");

    a_found_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_found |-> !o_overflow && (o_length_byte >= 8'd2))
        else $error("found frame with overflow or short length");

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready ##1 !o_ready ##1 !o_ready)
        else $error("new beat taken while search in flight");

    a_clr_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr |=> (r_fill == '0) && (r_run == 8'd0))
        else $error("store not cleared after frame or overflow");

endmodule
